// ===== hw/rtl/vrt_pkg.sv =====
// vrt_pkg: shared types and constants of the voxel ray traversal block
// no dependencies

package vrt_pkg;

    localparam int NUM_AXES = 3;

    // t of an axis that never moves: 2.0 in unsigned Q2.30
    localparam logic [31:0] T_TWO = 32'h8000_0000;

    // per-axis step direction codes
    typedef logic [1:0] step_sign_t;
    localparam step_sign_t SIGN_ZERO = 2'b00;
    localparam step_sign_t SIGN_POS  = 2'b01;
    localparam step_sign_t SIGN_NEG  = 2'b11;

endpackage

// ===== hw/rtl/voxel_ray_traversal_3d_top.sv =====
// voxel_ray_traversal_3d_top: 3-D voxel walk of one ray per item
// depends on vrt_pkg
//
// Usage
//   Input channel (in_valid/in_ready): one ray, start and end points in
//   voxel units, signed fixed point with COORD_FRAC_BITS fraction bits.
//   Output channel (out_valid/out_ready): the voxels crossed, from the floor
//   of start to the floor of end, one per item; last_voxel marks the end of
//   the run, cut_short marks a run stopped after MAX_STEPS steps.
//   Setup per ray: an axis step for each axis, plus, for each moving axis,
//   its two boundary divisions on the shared radix-4 divider (each a
//   saturation check, then restoring steps of two quotient bits each), plus
//   a finish step. Then the walk gives one voxel per cycle while out_ready
//   is high. in_ready is high only while no ray is in flight.
//   A stalled receiver holds the current voxel steady; the walk resumes
//   when it is taken.
//   Reset clears the sequencer; the block comes up idle and ready.

module voxel_ray_traversal_3d_top #(
    parameter int MAX_STEPS       = 63,
    parameter int COORD_FRAC_BITS = 16,
    parameter int INDEX_BITS      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic               last_voxel,
    output logic               cut_short
);
    import vrt_pkg::*;

    localparam int FB = COORD_FRAC_BITS;
    localparam int IB = INDEX_BITS;
    localparam int NW = FB + 31;
    localparam int HW = NW - 32;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int OW = (IB > 16) ? IB : 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AXIS = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RUN  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic signed [31:0]       start_reg [NUM_AXES], start_next [NUM_AXES];
    logic signed [31:0]       end_reg [NUM_AXES], end_next [NUM_AXES];
    logic [1:0]               ax_reg, ax_next;
    logic                     sel_reg, sel_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [31:0]              rem_reg, rem_next;
    logic [31:0]              low_reg, low_next;
    logic [31:0]              quo_reg, quo_next;
    logic                     sat_reg, sat_next;
    logic [32:0]              d_reg, d_next;
    logic [FB:0]              num_reg, num_next;
    logic [IB-1:0]            cell_reg [NUM_AXES], cell_next [NUM_AXES];
    step_sign_t               sign_reg [NUM_AXES], sign_next [NUM_AXES];
    logic [31:0]              tnext_reg [NUM_AXES], tnext_next [NUM_AXES];
    logic [31:0]              tper_reg [NUM_AXES], tper_next [NUM_AXES];
    logic [35:0]              man_reg, man_next;
    logic [SW-1:0]            steps_reg, steps_next;
    logic                     cut_reg, cut_next;

    // axis setup terms
    logic signed [33:0] s_ext, e_ext, s_fl, e_fl, diff;
    logic [33:0]        adiff;
    logic signed [32:0] delta;
    logic [32:0]        dabs;
    logic [FB-1:0]      fs;
    logic [FB:0]        num_w;

    // divider terms
    logic [NW-1:0] nsh;
    logic [HW-1:0] hi;
    logic [32:0]   t1, t2;
    logic [31:0]   r1, r2;
    logic          q1, q2;
    logic [31:0]   qres;

    // walk terms
    logic [1:0]  m;
    logic [32:0] tsum;
    logic        is_cut;

    assign s_ext = 34'(start_reg[ax_reg]);
    assign e_ext = 34'(end_reg[ax_reg]);
    assign s_fl  = s_ext >>> FB;
    assign e_fl  = e_ext >>> FB;
    assign diff  = e_fl - s_fl;
    assign adiff = diff[33] ? 34'(-diff) : 34'(diff);
    assign delta = 33'(end_reg[ax_reg]) - 33'(start_reg[ax_reg]);
    assign dabs  = delta[32] ? 33'(-delta) : 33'(delta);
    assign fs    = start_reg[ax_reg][FB-1:0];
    assign num_w = delta[32] ? {1'b0, fs} : ((FB+1)'(1) << FB) - {1'b0, fs};

    // dividend: distance to boundary or one full cell, scaled by 2^30
    assign nsh = sel_reg ? (NW'(1) << (FB + 30)) : (NW'(num_reg) << 30);
    assign hi  = nsh[NW-1:32];

    // two restoring steps per cycle
    assign t1   = {rem_reg, low_reg[31]};
    assign q1   = (t1 >= d_reg);
    assign r1   = q1 ? 32'(t1 - d_reg) : t1[31:0];
    assign t2   = {r1, low_reg[30]};
    assign q2   = (t2 >= d_reg);
    assign r2   = q2 ? 32'(t2 - d_reg) : t2[31:0];
    assign qres = sat_reg ? 32'hFFFF_FFFF : {quo_reg[29:0], q1, q2};

    // axis with smallest t, ties to the lower axis
    always_comb
    begin
        m = 2'd0;
        if (tnext_reg[1] < tnext_reg[m])
        begin
            m = 2'd1;
        end
        if (tnext_reg[2] < tnext_reg[m])
        begin
            m = 2'd2;
        end
    end

    assign tsum   = {1'b0, tnext_reg[m]} + {1'b0, tper_reg[m]};
    assign is_cut = (man_reg > 36'(MAX_STEPS));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        end_next   = end_reg;
        ax_next    = ax_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        d_next     = d_reg;
        num_next   = num_reg;
        cell_next  = cell_reg;
        sign_next  = sign_reg;
        tnext_next = tnext_reg;
        tper_next  = tper_reg;
        man_next   = man_reg;
        steps_next = steps_reg;
        cut_next   = cut_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next[0] = start_x;
                    start_next[1] = start_y;
                    start_next[2] = start_z;
                    end_next[0]   = end_x;
                    end_next[1]   = end_y;
                    end_next[2]   = end_z;
                    ax_next       = 2'd0;
                    man_next      = '0;
                    state_next    = S_AXIS;
                end
            end
            S_AXIS:
            begin
                cell_next[ax_reg] = s_fl[IB-1:0];
                man_next          = man_reg + 36'(adiff);
                d_next            = dabs;
                num_next          = num_w;
                sel_next          = 1'b0;
                if (delta == '0)
                begin
                    sign_next[ax_reg]  = SIGN_ZERO;
                    tnext_next[ax_reg] = T_TWO;
                    tper_next[ax_reg]  = T_TWO;
                    if (ax_reg == 2'd2)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                    end
                end
                else
                begin
                    sign_next[ax_reg] = delta[32] ? SIGN_NEG : SIGN_POS;
                    state_next        = S_LOAD;
                end
            end
            S_LOAD:
            begin
                sat_next   = (33'(hi) >= d_reg);
                rem_next   = 32'(hi);
                low_next   = nsh[31:0];
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = r2;
                low_next = {low_reg[29:0], 2'b00};
                quo_next = {quo_reg[29:0], q1, q2};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    if (!sel_reg)
                    begin
                        tnext_next[ax_reg] = qres;
                        sel_next           = 1'b1;
                        state_next         = S_LOAD;
                    end
                    else
                    begin
                        tper_next[ax_reg] = qres;
                        if (ax_reg == 2'd2)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            ax_next    = ax_reg + 2'd1;
                            state_next = S_AXIS;
                        end
                    end
                end
            end
            S_FIN:
            begin
                cut_next   = is_cut;
                steps_next = is_cut ? SW'(MAX_STEPS) : man_reg[SW-1:0];
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (out_ready)
                begin
                    if (steps_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (sign_reg[m] == SIGN_POS)
                        begin
                            cell_next[m] = cell_reg[m] + IB'(1);
                        end
                        else if (sign_reg[m] == SIGN_NEG)
                        begin
                            cell_next[m] = cell_reg[m] - IB'(1);
                        end
                        tnext_next[m] = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                        steps_next    = steps_reg - SW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
            man_reg   <= '0;
            steps_reg <= '0;
            cut_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                cell_reg[i] <= '0;
                sign_reg[i] <= SIGN_ZERO;
            end
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            man_reg   <= man_next;
            steps_reg <= steps_next;
            cut_reg   <= cut_next;
            sat_reg   <= sat_next;
            cell_reg  <= cell_next;
            sign_reg  <= sign_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quo_reg   <= quo_next;
        d_reg     <= d_next;
        num_reg   <= num_next;
        tnext_reg <= tnext_next;
        tper_reg  <= tper_next;
    end

    // outputs
    logic signed [OW-1:0] vx_w, vy_w, vz_w;
    assign vx_w = OW'($signed(cell_reg[0]));
    assign vy_w = OW'($signed(cell_reg[1]));
    assign vz_w = OW'($signed(cell_reg[2]));

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_RUN);
    assign voxel_x    = vx_w[15:0];
    assign voxel_y    = vy_w[15:0];
    assign voxel_z    = vz_w[15:0];
    assign last_voxel = (steps_reg == '0);
    assign cut_short  = (steps_reg == '0) && cut_reg;

endmodule

// ===== hw/rtl/vrt_checker.sv =====
// vrt_checker: port-level checks of the voxel ray traversal block
// depends on voxel_ray_traversal_3d_top; bound to it below

module vrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] voxel_x,
    input logic        last_voxel,
    input logic        cut_short
);

    // a stalled voxel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(voxel_x))
        else $error("stalled voxel changed");

    // cut flag only on the final voxel
    a_cut: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cut_short |-> last_voxel)
        else $error("cut_short without last_voxel");

    // no new ray while a run is shown
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready while emitting");

    // taking the last voxel ends the run
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_voxel |=> !out_valid && in_ready)
        else $error("run did not end");

    // an accepted ray blocks the input
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

endmodule

bind voxel_ray_traversal_3d_top vrt_checker u_vrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .voxel_x    (voxel_x),
    .last_voxel (last_voxel),
    .cut_short  (cut_short)
);

// ===== sim/tb_voxel_ray_traversal_3d_top.sv =====
// tb_voxel_ray_traversal_3d_top: self-checking bench for the 3-d voxel ray walk
// depends on vrt_pkg and voxel_ray_traversal_3d_top
`timescale 1ns / 1ps

module tb_voxel_ray_traversal_3d_top;
    import vrt_pkg::*;

    localparam int MAX_STEPS   = 63;
    localparam int FRAC_BITS   = 16;
    localparam longint ONE     = 64'sd65536;
    localparam longint T_LIMIT = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_RAYS = 390;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic               last;
        logic               cut;
    } voxel_t;

    // voxel walk predictor and queue of voxels still owed by the block
    class vrt_scoreboard;
        voxel_t voxel_q[$];
        int     errors;

        function new();
            voxel_q = {};
            errors = 0;
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        // walk one ray and queue every voxel it crosses
        function void note_ray(logic signed [31:0] sp[3], logic signed [31:0] ep[3]);
            logic [15:0]  cell_idx[3];
            logic [31:0]  t_next[3];
            logic [31:0]  t_step[3];
            step_sign_t   dir[3];
            longint       s, e, cs, ce, delta, d, num, q, sum, manhattan;
            int           steps, m;
            bit           cut;
            voxel_t       v;
            manhattan = 0;
            for (int a = 0; a < 3; a++)
            begin
                s = sp[a];
                e = ep[a];
                cs = s >>> FRAC_BITS;
                ce = e >>> FRAC_BITS;
                manhattan += (ce > cs) ? ce - cs : cs - ce;
                cell_idx[a] = cs[15:0];
                delta = e - s;
                if (delta == 0)
                begin
                    dir[a] = SIGN_ZERO;
                    t_next[a] = T_TWO;
                    t_step[a] = T_TWO;
                end
                else
                begin
                    d = (delta < 0) ? -delta : delta;
                    dir[a] = (delta > 0) ? SIGN_POS : SIGN_NEG;
                    num = (delta > 0) ? ONE - (s & (ONE - 1)) : (s & (ONE - 1));
                    q = (num <<< 30) / d;
                    t_next[a] = (q > T_LIMIT) ? 32'hFFFF_FFFF : q[31:0];
                    q = (64'sd1 <<< (FRAC_BITS + 30)) / d;
                    t_step[a] = (q > T_LIMIT) ? 32'hFFFF_FFFF : q[31:0];
                end
            end
            cut = manhattan > MAX_STEPS;
            steps = cut ? MAX_STEPS : int'(manhattan);
            forever
            begin
                v.vx = cell_idx[0];
                v.vy = cell_idx[1];
                v.vz = cell_idx[2];
                v.last = (steps == 0);
                v.cut = v.last && cut;
                voxel_q.push_back(v);
                if (steps == 0)
                    break;
                // smallest boundary wins, ties go to the lower axis
                m = 0;
                if (t_next[1] < t_next[m]) m = 1;
                if (t_next[2] < t_next[m]) m = 2;
                if (dir[m] == SIGN_POS)
                    cell_idx[m] = cell_idx[m] + 16'd1;
                else if (dir[m] == SIGN_NEG)
                    cell_idx[m] = cell_idx[m] - 16'd1;
                sum = longint'(t_next[m]) + longint'(t_step[m]);
                t_next[m] = (sum > T_LIMIT) ? 32'hFFFF_FFFF : sum[31:0];
                steps--;
            end
        endfunction

        function void check_voxel(voxel_t got);
            voxel_t want;
            if (voxel_q.size() == 0)
            begin
                report($sformatf("unexpected voxel (%0d,%0d,%0d)", got.vx, got.vy, got.vz));
                return;
            end
            want = voxel_q.pop_front();
            if (got.vx !== want.vx)
                report($sformatf("voxel_x %0d, want %0d", got.vx, want.vx));
            if (got.vy !== want.vy)
                report($sformatf("voxel_y %0d, want %0d", got.vy, want.vy));
            if (got.vz !== want.vz)
                report($sformatf("voxel_z %0d, want %0d", got.vz, want.vz));
            if (got.last !== want.last)
                report($sformatf("last_voxel %b, want %b", got.last, want.last));
            if (got.cut !== want.cut)
                report($sformatf("cut_short %b, want %b", got.cut, want.cut));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] voxel_x, voxel_y, voxel_z;
    logic               last_voxel, cut_short;

    vrt_scoreboard sb = new();
    bit  sender_busy_free = 1'b0;
    bit  sink_no_idle = 1'b0;
    bit  hold_request = 1'b0;
    int  cycles = 0;

    voxel_ray_traversal_3d_top dut (.*);

    always #4 clk = ~clk;

    // check each voxel taken
    always @(posedge clk)
    begin
        voxel_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.vx = voxel_x;
            got.vy = voxel_y;
            got.vz = voxel_z;
            got.last = last_voxel;
            got.cut = cut_short;
            sb.check_voxel(got);
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_request = 1'b0;
            end
            out_ready <= sink_no_idle ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one ray and hold it until taken; valid stays up for a back-to-back item
    task automatic send_ray(logic signed [31:0] sp[3], logic signed [31:0] ep[3]);
        int gap;
        gap = (!sender_busy_free && $urandom_range(99) < 27) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= sp[0]; start_y <= sp[1]; start_z <= sp[2];
        end_x <= ep[0]; end_y <= ep[1]; end_z <= ep[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_ray(sp, ep);
    endtask

    task automatic send_xyz(int sx, int sy, int sz, int ex, int ey, int ez);
        logic signed [31:0] sp[3];
        logic signed [31:0] ep[3];
        sp = '{sx, sy, sz};
        ep = '{ex, ey, ez};
        send_ray(sp, ep);
    endtask

    // random ray: mostly short walks with random content, some long and odd ones
    task automatic send_random_ray();
        logic signed [31:0] sp[3];
        logic signed [31:0] ep[3];
        int kind;
        kind = $urandom_range(99);
        for (int a = 0; a < 3; a++)
        begin
            sp[a] = $urandom;
            if (kind < 70)
                ep[a] = sp[a] + $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
            else if (kind < 80)
                ep[a] = $urandom;
            else if (kind < 90)
            begin
                // grid-aligned start, often a still axis
                sp[a] = sp[a] & 32'hFFFF_0000;
                ep[a] = ($urandom_range(2) == 0) ? sp[a] :
                        sp[a] + ($signed($urandom_range(0, 8)) - 4) * 65536;
            end
            else
                ep[a] = sp[a] + $signed($urandom_range(0, 50 * 65536)) - 25 * 65536;
        end
        send_ray(sp, ep);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rays
        send_xyz(0, 0, 0, 0, 0, 0);
        send_xyz(32768, 32768, 32768, 163840, 163840, 163840);
        send_xyz(131072, 0, 0, 32768, 0, 0);
        send_xyz(0, 131072, 0, 0, 32768, 0);
        send_xyz(0, 0, 131072, 0, 0, 32768);
        send_xyz(-98304, -5, 7, 98304, -5, 7);
        send_xyz(100, 200, 300, 100, 200 + 4 * 65536, 300);
        send_xyz(100, 200, 300, 100, 200, 300 - 4 * 65536);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0, 65536);
        send_xyz(32'h8000_0000, 1, 2, 32'h8000_0001, 1, 2);
        send_xyz(0, 0, 0, 63 * 65536, 0, 0);
        send_xyz(0, 0, 0, 64 * 65536, 0, 0);
        send_xyz(0, 0, 0, 21 * 65536, 21 * 65536, 21 * 65536 + 100);
        send_xyz(-1, -1, -1, 1, 1, 1);
        send_xyz(65536, 65536, 65536, 0, 0, 0);
        send_xyz(10, 20, 30, 10 + 3 * 65536, 20 - 2 * 65536, 30 + 65536);
        send_xyz(0, 0, 0, 65536 + 1, 65536, 0);

        // random rays; no idling on the sender for a stretch
        for (int i = 0; i < RANDOM_RAYS; i++)
        begin
            if (i == 60)  sender_busy_free = 1'b1;
            if (i == 100) sender_busy_free = 1'b0;
            if (i == 120) sink_no_idle = 1'b1;
            if (i == 160) sink_no_idle = 1'b0;
            if (i == 200) hold_request = 1'b1;
            if (i == 250)
            begin
                // pause until the block has drained
                in_valid <= 1'b0;
                while (sb.voxel_q.size() != 0)
                    @(posedge clk);
            end
            send_random_ray();
        end
        in_valid <= 1'b0;

        while (sb.voxel_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
